// ===== design/ortt_pkg.sv =====
// shared types and codes for the owner-tagged range table
// no dependencies; used by ortt_ctrl, ortt_dp and owner_tagged_range_table_core

package ortt_pkg;

  // request kinds
  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_DEL   = 2'd1,
    KIND_QUERY = 2'd2
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic start;  // latch request, clear scan state
    logic issue;  // scan one slot this cycle
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;   // slot being issued is the final one
    logic busy;   // compare pipeline still holds slots
  } dp_sts_t;

endpackage

// ===== design/owner_tagged_range_table_core.sv =====
// top level of the owner-tagged range table
// depends on ortt_pkg, ortt_ctrl, ortt_dp (and ortt_ram below it)

// Table of TABLE_ENTRIES address regions, each tagged with an owner id, a
// base and a length; a clear used bit marks a slot free and the table is empty
// after reset (per-slot used flags clear at once, no clearing pass). Kind 0
// adds a region in the lowest free slot and returns status 1 when none is
// free; kind 1 deletes every slot that matches owner, base and length
// exactly; kind 2 returns mapped 1 when the address falls inside a used
// region of the same owner (the region end is formed one bit wider, so it
// never wraps). Kind 3 changes nothing and answers with zeros. Every request
// gets exactly one response. After acceptance the block walks the slot ram
// one entry per cycle through its single read port and a two-stage compare
// pipeline, drains the pipeline, then holds the response until it is taken
// and returns to ready. One request is in flight at a time; in_ready is high
// only while the block is idle.

module owner_tagged_range_table_core #(
  parameter int TABLE_ENTRIES = 64,
  parameter int ADDR_BITS     = 48,
  parameter int OWNER_BITS    = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_kind,
  input  logic [OWNER_BITS-1:0] in_owner,
  input  logic [ADDR_BITS-1:0]  in_address,
  input  logic [ADDR_BITS-1:0]  in_length,
  // response channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_status,
  output logic                  out_mapped
);

  // command and status between sequencer and scan datapath
  ortt_pkg::dp_cmd_t cmd;
  ortt_pkg::dp_sts_t sts;

  // sequencer: idle, scan all slots, drain the compare pipe, hold response
  ortt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: request latch, slot ram, used flags, result flags
  ortt_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ADDR_BITS     (ADDR_BITS),
    .OWNER_BITS    (OWNER_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_kind    (in_kind),
    .in_owner   (in_owner),
    .in_address (in_address),
    .in_length  (in_length),
    .out_status (out_status),
    .out_mapped (out_mapped)
  );

endmodule

// ===== design/ortt_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies

module ortt_ram #(
  parameter int WIDTH = 104,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ortt_ctrl.sv =====
// request sequencer for the owner-tagged range table
// depends on ortt_pkg; drives ortt_dp through dp_cmd_t / dp_sts_t

module ortt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output ortt_pkg::dp_cmd_t cmd,
  input  ortt_pkg::dp_sts_t sts
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_RESP  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.busy) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/ortt_dp.sv =====
// slot scan datapath: used flags, slot ram, compare pipeline, result flags
// depends on ortt_pkg and ortt_ram

module ortt_dp #(
  parameter int TABLE_ENTRIES = 64,
  parameter int ADDR_BITS     = 48,
  parameter int OWNER_BITS    = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ortt_pkg::dp_cmd_t     cmd,
  output ortt_pkg::dp_sts_t     sts,
  input  logic [1:0]            in_kind,
  input  logic [OWNER_BITS-1:0] in_owner,
  input  logic [ADDR_BITS-1:0]  in_address,
  input  logic [ADDR_BITS-1:0]  in_length,
  output logic                  out_status,
  output logic                  out_mapped
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int ENT_W = OWNER_BITS + 2 * ADDR_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // latched request
  logic [1:0]            req_kind_r;
  logic [OWNER_BITS-1:0] req_owner_r;
  logic [ADDR_BITS-1:0]  req_addr_r;
  logic [ADDR_BITS-1:0]  req_len_r;

  logic [TABLE_ENTRIES-1:0] used_r, used_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic                     found_r, found_nxt;
  logic                     hit_r, hit_nxt;

  // compare pipeline
  logic                 s1_v_r;
  logic [IDX_W-1:0]     s1_idx_r;
  logic                 s2_v_r;
  logic                 s2_cand_r;
  logic [ADDR_BITS:0]   s2_end_r;

  logic                  ram_we;
  logic [ENT_W-1:0]      ram_wdata;
  logic [ENT_W-1:0]      ram_rdata;
  logic [OWNER_BITS-1:0] ent_owner;
  logic [ADDR_BITS-1:0]  ent_base;
  logic [ADDR_BITS-1:0]  ent_len;
  logic                  ent_used;
  logic                  is_add, is_del, is_query;

  assign is_add   = (req_kind_r == ortt_pkg::KIND_ADD);
  assign is_del   = (req_kind_r == ortt_pkg::KIND_DEL);
  assign is_query = (req_kind_r == ortt_pkg::KIND_QUERY);

  assign ram_wdata = {req_owner_r, req_addr_r, req_len_r};
  assign {ent_owner, ent_base, ent_len} = ram_rdata;
  assign ent_used = used_r[s1_idx_r];

  ortt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    used_nxt  = used_r;
    idx_nxt   = idx_r;
    found_nxt = found_r;
    hit_nxt   = hit_r;
    ram_we    = 1'b0;
    if (cmd.start) begin
      idx_nxt   = '0;
      found_nxt = 1'b0;
      hit_nxt   = 1'b0;
    end
    if (cmd.issue) begin
      idx_nxt = idx_r + IDX_W'(1);
      // add takes the lowest free slot; a zero length leaves it free
      if (is_add && !found_r && !used_r[idx_r]) begin
        found_nxt = 1'b1;
        if (req_len_r != '0) begin
          ram_we          = 1'b1;
          used_nxt[idx_r] = 1'b1;
        end
      end
    end
    // delete only touches used slots; the ram keeps stale contents in free ones
    if (s1_v_r && is_del && ent_used && ent_owner == req_owner_r &&
        ent_base == req_addr_r && ent_len == req_len_r) begin
      used_nxt[s1_idx_r] = 1'b0;
    end
    if (s2_v_r && is_query && s2_cand_r && ({1'b0, req_addr_r} < s2_end_r)) begin
      hit_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      idx_r   <= '0;
      found_r <= 1'b0;
      hit_r   <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
    end else begin
      used_r  <= used_nxt;
      idx_r   <= idx_nxt;
      found_r <= found_nxt;
      hit_r   <= hit_nxt;
      s1_v_r  <= cmd.issue;
      s2_v_r  <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_kind_r  <= in_kind;
      req_owner_r <= in_owner;
      req_addr_r  <= in_address;
      req_len_r   <= in_length;
    end
    s1_idx_r  <= idx_r;
    s2_cand_r <= ent_used && (ent_owner == req_owner_r) && (req_addr_r >= ent_base);
    s2_end_r  <= {1'b0, ent_base} + {1'b0, ent_len};
  end

  assign sts.last = (idx_r == LAST_IDX);
  assign sts.busy = s1_v_r | s2_v_r;

  assign out_status = is_add & ~found_r;
  assign out_mapped = is_query & hit_r;

endmodule

// ===== sim/ortt_checker.sv =====
// request/response checker for the owner-tagged range table
// depends on ortt_pkg; instantiated beside the core by owner_tagged_range_table_core_tb

`timescale 1ns / 1ps

module ortt_checker #(
  parameter int TABLE_ENTRIES = 64,
  parameter int ADDR_BITS     = 48,
  parameter int OWNER_BITS    = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [1:0]            in_kind,
  input  logic [OWNER_BITS-1:0] in_owner,
  input  logic [ADDR_BITS-1:0]  in_address,
  input  logic [ADDR_BITS-1:0]  in_length,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_status,
  input  logic                  out_mapped,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic status;
    logic mapped;
  } reply_t;

  // shadow copy of the slot table
  logic [OWNER_BITS-1:0] region_owner [TABLE_ENTRIES];
  logic [ADDR_BITS-1:0]  region_base  [TABLE_ENTRIES];
  logic [ADDR_BITS-1:0]  region_len   [TABLE_ENTRIES];

  reply_t expected_replies [$];
  reply_t want;

  // applies one request to the shadow table and returns its reply
  function automatic reply_t apply_request(ortt_pkg::kind_t kind,
                                           logic [OWNER_BITS-1:0] owner,
                                           logic [ADDR_BITS-1:0] addr,
                                           logic [ADDR_BITS-1:0] len);
    reply_t          r;
    logic            placed;
    logic [ADDR_BITS:0] stop;
    r      = '0;
    placed = 1'b0;
    case (kind)
      ortt_pkg::KIND_ADD: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (!placed && region_len[i] == '0) begin
            region_owner[i] = owner;
            region_base[i]  = addr;
            region_len[i]   = len;
            placed          = 1'b1;
          end
        end
        r.status = !placed;
      end
      ortt_pkg::KIND_DEL: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (region_owner[i] == owner && region_base[i] == addr && region_len[i] == len) begin
            region_owner[i] = '0;
            region_base[i]  = '0;
            region_len[i]   = '0;
          end
        end
      end
      ortt_pkg::KIND_QUERY: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (region_owner[i] == owner && region_len[i] != '0) begin
            // one bit wider so the end never wraps
            stop = {1'b0, region_base[i]} + {1'b0, region_len[i]};
            if (addr >= region_base[i] && {1'b0, addr} < stop) r.mapped = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        region_owner[i] = '0;
        region_base[i]  = '0;
        region_len[i]   = '0;
      end
      expected_replies.delete();
      pending <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_replies.push_back(apply_request(ortt_pkg::kind_t'(in_kind), in_owner,
                                                 in_address, in_length));
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: response with none expected: status %0b mapped %0b",
                     $time, out_status, out_mapped);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_replies.pop_front();
          if (want.status !== out_status || want.mapped !== out_mapped) begin
            if (fail_count < 10)
              $display("%0t: response mismatch: status exp %0b got %0b, mapped exp %0b got %0b",
                       $time, want.status, out_status, want.mapped, out_mapped);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_replies.size();
    end
  end

endmodule

// ===== sim/owner_tagged_range_table_core_tb.sv =====
// stimulus and verdict for the owner-tagged range table core
// depends on ortt_pkg, owner_tagged_range_table_core and ortt_checker

`timescale 1ns / 1ps

module owner_tagged_range_table_core_tb;

  localparam int TABLE_ENTRIES = 64;
  localparam int ADDR_BITS     = 48;
  localparam int OWNER_BITS    = 8;
  // the fourth kind code has no operation behind it
  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [ADDR_BITS-1:0] ADDR_TOP = '1;
  localparam int ITEMS_PER_PHASE = 660;
  localparam int BURST_ITEMS     = 60;

  typedef struct {
    logic [OWNER_BITS-1:0] owner;
    logic [ADDR_BITS-1:0]  base;
    logic [ADDR_BITS-1:0]  len;
  } region_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_kind;
  logic [OWNER_BITS-1:0] in_owner;
  logic [ADDR_BITS-1:0]  in_address;
  logic [ADDR_BITS-1:0]  in_length;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_status;
  logic                  out_mapped;
  int                    fail_count;
  int                    pending;

  // idle rates in percent per cycle, changed per phase
  int send_idle = 0;
  int recv_idle = 0;

  // regions the stimulus has tried to add; only used to aim deletes and queries
  region_t placed_regions [$];

  owner_tagged_range_table_core #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ADDR_BITS     (ADDR_BITS),
    .OWNER_BITS    (OWNER_BITS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_kind    (in_kind),
    .in_owner   (in_owner),
    .in_address (in_address),
    .in_length  (in_length),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_mapped (out_mapped)
  );

  ortt_checker #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ADDR_BITS     (ADDR_BITS),
    .OWNER_BITS    (OWNER_BITS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_kind    (in_kind),
    .in_owner   (in_owner),
    .in_address (in_address),
    .in_length  (in_length),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_mapped (out_mapped),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // response side back-pressure, one draw per cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // hard stop well past the slowest legal run
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [ADDR_BITS-1:0] rand_wide();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[ADDR_BITS-1:0];
  endfunction

  // owners mostly from a small pool so regions collide across owners
  function automatic logic [OWNER_BITS-1:0] rand_owner();
    if ($urandom_range(3) != 0) return OWNER_BITS'($urandom_range(3));
    return OWNER_BITS'($urandom);
  endfunction

  // bases cluster in a few pages, with some anywhere and some near the top
  function automatic logic [ADDR_BITS-1:0] rand_base();
    int pick;
    pick = $urandom_range(9);
    if (pick < 6) return ADDR_BITS'($urandom_range(15)) << 12;
    if (pick < 9) return rand_wide();
    return ADDR_TOP - ADDR_BITS'($urandom_range(4095));
  endfunction

  function automatic logic [ADDR_BITS-1:0] rand_len();
    int pick;
    pick = $urandom_range(9);
    case (pick)
      0:       return '0;
      1:       return ADDR_TOP;
      2, 3:    return rand_wide();
      4:       return ADDR_BITS'($urandom_range(1, 4));
      default: return ADDR_BITS'($urandom_range(1, 8192));
    endcase
  endfunction

  // one request: optional idle gap, then hold valid until the core takes it
  task automatic send_request(input logic [1:0] kind, input logic [OWNER_BITS-1:0] owner,
                              input logic [ADDR_BITS-1:0] addr,
                              input logic [ADDR_BITS-1:0] len);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_owner   <= owner;
    in_address <= addr;
    in_length  <= len;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic add_region(input logic [OWNER_BITS-1:0] owner,
                            input logic [ADDR_BITS-1:0] base, input logic [ADDR_BITS-1:0] len);
    region_t r;
    r.owner = owner;
    r.base  = base;
    r.len   = len;
    placed_regions.push_back(r);
    if (placed_regions.size() > 256) void'(placed_regions.pop_front());
    send_request(ortt_pkg::KIND_ADD, owner, base, len);
  endtask

  task automatic delete_region(input logic [OWNER_BITS-1:0] owner,
                               input logic [ADDR_BITS-1:0] base,
                               input logic [ADDR_BITS-1:0] len);
    for (int i = placed_regions.size() - 1; i >= 0; i--) begin
      if (placed_regions[i].owner == owner && placed_regions[i].base == base &&
          placed_regions[i].len == len)
        placed_regions.delete(i);
    end
    send_request(ortt_pkg::KIND_DEL, owner, base, len);
  endtask

  // one random request; add and delete shares set by the current burst
  task automatic random_request(input int add_pct, input int del_pct);
    int      pick;
    int      edge_pick;
    region_t r;
    logic [ADDR_BITS-1:0] probe;
    logic [OWNER_BITS-1:0] who;
    pick = $urandom_range(99);
    if (placed_regions.size() != 0)
      r = placed_regions[$urandom_range(placed_regions.size() - 1)];
    if (pick < add_pct) begin
      add_region(rand_owner(), rand_base(), rand_len());
    end else if (pick < add_pct + del_pct) begin
      if (placed_regions.size() != 0 && $urandom_range(9) < 8) begin
        delete_region(r.owner, r.base, r.len);
      end else if (placed_regions.size() != 0 && $urandom_range(1) == 0) begin
        // near miss: same region with the length off by one
        delete_region(r.owner, r.base, r.len + 1'b1);
      end else begin
        delete_region(rand_owner(), rand_base(), rand_len());
      end
    end else if (pick < 97) begin
      if (placed_regions.size() != 0 && $urandom_range(3) != 0) begin
        who       = r.owner;
        edge_pick = $urandom_range(6);
        case (edge_pick)
          0:       probe = r.base;
          1:       probe = r.base + r.len - 1'b1;
          2:       probe = r.base + r.len;
          3:       probe = r.base - 1'b1;
          4:       probe = r.base + ADDR_BITS'($urandom_range(8191));
          5: begin
            probe = r.base;
            who   = r.owner ^ OWNER_BITS'($urandom_range(1, 255));
          end
          default: probe = rand_wide();
        endcase
      end else begin
        who   = rand_owner();
        probe = ($urandom_range(1) == 0) ? rand_base() : rand_wide();
      end
      send_request(ortt_pkg::KIND_QUERY, who, probe, rand_wide());
    end else begin
      send_request(KIND_NONE, OWNER_BITS'($urandom), rand_wide(), rand_wide());
    end
  endtask

  initial begin
    int mode;
    int add_pct;
    int del_pct;
    in_valid   <= 1'b0;
    in_kind    <= ortt_pkg::KIND_ADD;
    in_owner   <= '0;
    in_address <= '0;
    in_length  <= '0;
    rst_n      <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, no idling
    // empty table: a query for owner 0 at address 0 must never hit
    send_request(ortt_pkg::KIND_QUERY, '0, '0, '0);
    // zero-length add writes nothing and leaves every slot free
    add_region('0, '0, '0);
    send_request(ortt_pkg::KIND_QUERY, '0, '0, ADDR_TOP);
    // region at the very top with maximum length, end must not wrap
    add_region('1, ADDR_TOP, ADDR_TOP);
    send_request(ortt_pkg::KIND_QUERY, '1, ADDR_TOP, '0);
    send_request(ortt_pkg::KIND_QUERY, '1, ADDR_TOP - 1'b1, '0);
    send_request(ortt_pkg::KIND_QUERY, '1, '0, '0);
    // ordinary region, both edges and both neighbors
    add_region(8'h01, 48'h1000, 48'h100);
    send_request(ortt_pkg::KIND_QUERY, 8'h01, 48'h1000, '0);
    send_request(ortt_pkg::KIND_QUERY, 8'h01, 48'h10ff, '0);
    send_request(ortt_pkg::KIND_QUERY, 8'h01, 48'h1100, '0);
    send_request(ortt_pkg::KIND_QUERY, 8'h01, 48'h0fff, '0);
    // same address under another owner
    send_request(ortt_pkg::KIND_QUERY, 8'h02, 48'h1000, '0);
    // unknown kind touches nothing
    send_request(KIND_NONE, '1, ADDR_TOP, ADDR_TOP);
    // delete must match length exactly
    delete_region(8'h01, 48'h1000, 48'hff);
    send_request(ortt_pkg::KIND_QUERY, 8'h01, 48'h1000, '0);
    delete_region(8'h01, 48'h1000, 48'h100);
    send_request(ortt_pkg::KIND_QUERY, 8'h01, 48'h1000, '0);
    // zero-length delete on free slots
    delete_region('0, '0, '0);
    // duplicates: one delete clears both copies
    add_region(8'h03, 48'h5000, 48'h10);
    add_region(8'h03, 48'h5000, 48'h10);
    delete_region(8'h03, 48'h5000, 48'h10);
    send_request(ortt_pkg::KIND_QUERY, 8'h03, 48'h5008, '0);
    send_request(ortt_pkg::KIND_QUERY, '1, ADDR_TOP, ADDR_TOP);

    // random part in three idling phases, each burst picked at random among
    // filling the table to overflow, draining it and a plain mix
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 28;
          recv_idle = 59;
        end
        1: begin
          send_idle = 59;
          recv_idle = 28;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % BURST_ITEMS == 0) begin
          mode = $urandom_range(2);
          case (mode)
            0: begin
              add_pct = 75;
              del_pct = 8;
            end
            1: begin
              add_pct = 12;
              del_pct = 60;
            end
            default: begin
              add_pct = 35;
              del_pct = 25;
            end
          endcase
        end
        random_request(add_pct, del_pct);
      end
    end
    in_valid <= 1'b0;

    // drain outstanding responses, then let the core settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 8) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/ortt_pkg.sv
design/ortt_ram.sv
design/ortt_ctrl.sv
design/ortt_dp.sv
design/owner_tagged_range_table_core.sv
sim/ortt_checker.sv
sim/owner_tagged_range_table_core_tb.sv
